// ===== sv/bezier_curve_evaluator_unit_defines.svh =====
// ----------------------------------------------------------------------------
// bezier curve evaluator assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef BEZIER_CURVE_EVALUATOR_UNIT_DEFINES_SVH
`define BEZIER_CURVE_EVALUATOR_UNIT_DEFINES_SVH

// same-cycle implication
`define BCE_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define BCE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/bce_pkg.sv =====
// ----------------------------------------------------------------------------
// bce_pkg
// types and constants of the bezier curve evaluator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bce_pkg;

   localparam int T_FRAC     = 16;
   localparam int T_W        = T_FRAC + 1;
   localparam int ADDR_W     = 5;
   localparam int LEN_W      = 24;

   localparam logic [T_W-1:0]   T_ONE   = 17'h10000;
   localparam logic [LEN_W-1:0] LEN_MAX = 24'hFFFFFF;

   localparam logic OP_EVAL   = 1'b0;
   localparam logic OP_LENGTH = 1'b1;

   localparam logic [2:0] REG_START   = 3'd0;
   localparam logic [2:0] REG_END     = 3'd1;
   localparam logic [2:0] REG_CTRL1   = 3'd2;
   localparam logic [2:0] REG_CTRL2   = 3'd3;
   localparam logic [2:0] REG_DEGREE  = 3'd4;

   typedef struct packed {
      logic            opcode;
      logic [T_W-1:0]  param_value;
   } req_type;

   typedef struct packed {
      logic signed [15:0] point_x;
      logic signed [15:0] point_y;
      logic [LEN_W-1:0]   curve_length;
      logic               bad_step;
   } rsp_type;

   typedef struct packed {
      logic [31:0] start_point;
      logic [31:0] end_point;
      logic [31:0] control_one;
      logic [31:0] control_two;
      logic        degree_mode;
   } cfg_type;

   typedef enum logic [1:0] {
      JOB_POINT,
      JOB_LENGTH,
      JOB_BAD_STEP
   } job_kind_type;

   typedef struct packed {
      job_kind_type    kind;
      logic [T_W-1:0]  param;
   } job_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQUARE_T,
      ST_WEIGHT,
      ST_PRODUCT,
      ST_SUM,
      ST_DELTA,
      ST_LOAD,
      ST_ROOT,
      ST_ACCUM,
      ST_DONE
   } eng_state_type;

endpackage

// ===== sv/bce_front.sv =====
// ----------------------------------------------------------------------------
// bce_front
// accepts requests, sorts them into jobs and clamps the curve parameter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bce_front (
   input  bce_pkg::req_type req_data,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic             q_full,
   output logic             q_push,
   output bce_pkg::job_type q_job
);
   import bce_pkg::*;

   always_comb begin
      req_ready = !q_full;
      q_push    = req_valid && !q_full;
      q_job     = '{kind: JOB_POINT, param: req_data.param_value};
      if (req_data.opcode == OP_LENGTH) begin
         q_job.kind = (req_data.param_value == '0) ? JOB_BAD_STEP : JOB_LENGTH;
      end else if (req_data.param_value > T_ONE) begin
         q_job.param = T_ONE;
      end
   end

endmodule

// ===== sv/bce_queue.sv =====
// ----------------------------------------------------------------------------
// bce_queue
// two-entry job queue between front and engine
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bce_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  bce_pkg::job_type push_job,
   output logic             full,
   input  logic             pop,
   output logic             not_empty,
   output bce_pkg::job_type head_job
);
   import bce_pkg::*;

   job_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_pop;

   always_comb begin
      full      = (count_ff == 2'd2);
      not_empty = (count_ff != 2'd0);
      head_job  = slot_ff[rd_ptr_ff];
      do_pop    = pop && not_empty;
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// ===== sv/bce_engine.sv =====
// ----------------------------------------------------------------------------
// bce_engine
// point evaluation stages, chord square root and length accumulation
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bce_engine (
   input  logic             clock,
   input  logic             reset,
   input  bce_pkg::cfg_type cfg,
   input  logic             q_valid,
   input  bce_pkg::job_type q_job,
   output logic             q_pop,
   output bce_pkg::rsp_type rsp_data,
   output logic             rsp_valid,
   input  logic             rsp_ready
);
   import bce_pkg::*;

   localparam logic [33:0] RND_HALF   = 34'h8000;
   localparam logic [33:0] ROOT_START = 34'h1_0000_0000;
   localparam logic [4:0]  ROOT_LAST  = 5'd16;

   eng_state_type state_ff, state_in;
   logic                 len_mode_ff, len_mode_in;
   logic                 cubic_ff, cubic_in;
   logic                 first_ff, first_in;
   logic [T_W-1:0]       step_ff, step_in;
   logic [T_W-1:0]       t_ff, t_in;
   logic [T_W-1:0]       uu_ff, uu_in;
   logic [T_W-1:0]       tt_ff, tt_in;
   logic [18:0]          w_ff [4];
   logic [18:0]          w_in [4];
   logic signed [36:0]   prod_ff [2][4];
   logic signed [36:0]   prod_in [2][4];
   logic signed [15:0]   pt_ff [2];
   logic signed [15:0]   pt_in [2];
   logic signed [15:0]   prev_ff [2];
   logic signed [15:0]   prev_in [2];
   logic [32:0]          sq_ff [2];
   logic [32:0]          sq_in [2];
   logic [33:0]          rem_ff, rem_in;
   logic [33:0]          root_ff, root_in;
   logic [33:0]          bit_ff, bit_in;
   logic [4:0]           cnt_ff, cnt_in;
   logic [LEN_W-1:0]     acc_ff, acc_in;
   rsp_type              result_ff, result_in;
   rsp_type              rsp_ff, rsp_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   logic [T_W-1:0]       u;
   logic [33:0]          m_a, m_b, m_c, m_d;
   logic [T_W-1:0]       r_b, r_c;
   logic [17:0]          t_sum;
   logic [T_W-1:0]       t_next;
   logic signed [16:0]   cb [2][4];
   logic signed [16:0]   p1, p2, c1, c2;
   logic signed [39:0]   sum [2];
   logic signed [39:0]   rounded [2];
   logic signed [16:0]   dx [2];
   logic signed [33:0]   dsq [2];
   logic [34:0]          trial;
   logic [24:0]          acc_sum;

   function automatic logic signed [16:0] coord(input logic [31:0] pt, input int k);
      return (k == 0) ? 17'(signed'(pt[31:16])) : 17'(signed'(pt[15:0]));
   endfunction

   function automatic logic signed [15:0] sat16(input logic signed [39:0] v);
      if (v > 40'sd32767) begin
         return 16'sh7FFF;
      end else if (v < -40'sd32768) begin
         return 16'sh8000;
      end
      return v[15:0];
   endfunction

   always_comb begin
      u      = T_ONE - t_ff;
      t_sum  = 18'(t_ff) + 18'(step_ff);
      t_next = (t_sum > 18'(T_ONE)) ? T_ONE : t_sum[T_W-1:0];
      m_a    = 34'(u) * 34'(u);
      m_b    = 34'(t_ff) * 34'(t_ff);
      m_c    = 34'(uu_ff) * 34'(t_ff);
      m_d    = 34'(tt_ff) * 34'(u);
      r_b    = 17'((m_c + RND_HALF) >> T_FRAC);
      r_c    = 17'((m_d + RND_HALF) >> T_FRAC);
      trial  = 35'(root_ff) + 35'(bit_ff);
      acc_sum = 25'(acc_ff) + 25'(root_ff[16:0]);

      for (int k = 0; k < 2; k++) begin
         p1 = coord(cfg.start_point, k);
         p2 = coord(cfg.end_point, k);
         c1 = coord(cfg.control_one, k);
         c2 = coord(cfg.control_two, k);
         if (cubic_ff) begin
            cb[k][0] = p1;
            cb[k][1] = c1;
            cb[k][2] = c2;
            cb[k][3] = p2;
            sum[k]   = '0;
         end else begin
            cb[k][0] = p1 - c1;
            cb[k][1] = p2 - c1;
            cb[k][2] = '0;
            cb[k][3] = '0;
            sum[k]   = {{7{c1[16]}}, c1, 16'b0};
         end
         for (int j = 0; j < 4; j++) begin
            prod_in[k][j] = signed'({1'b0, w_ff[j]}) * cb[k][j];
            sum[k]        = sum[k] + 40'(prod_ff[k][j]);
         end
         rounded[k] = (sum[k] + 40'sh8000) >>> T_FRAC;
         dx[k]      = 17'(pt_ff[k]) - 17'(prev_ff[k]);
         dsq[k]     = dx[k] * dx[k];
      end

      state_in     = state_ff;
      len_mode_in  = len_mode_ff;
      cubic_in     = cubic_ff;
      first_in     = first_ff;
      step_in      = step_ff;
      t_in         = t_ff;
      uu_in        = uu_ff;
      tt_in        = tt_ff;
      w_in         = w_ff;
      pt_in        = pt_ff;
      prev_in      = prev_ff;
      sq_in        = sq_ff;
      rem_in       = rem_ff;
      root_in      = root_ff;
      bit_in       = bit_ff;
      cnt_in       = cnt_ff;
      acc_in       = acc_ff;
      result_in    = result_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      q_pop        = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            q_pop = q_valid;
            if (q_valid) begin
               case (q_job.kind)
                  JOB_POINT: begin
                     len_mode_in = 1'b0;
                     cubic_in    = cfg.degree_mode;
                     t_in        = q_job.param;
                     state_in    = ST_SQUARE_T;
                  end
                  JOB_LENGTH: begin
                     len_mode_in = 1'b1;
                     cubic_in    = 1'b1;
                     first_in    = 1'b1;
                     step_in     = q_job.param;
                     t_in        = '0;
                     acc_in      = '0;
                     state_in    = ST_SQUARE_T;
                  end
                  JOB_BAD_STEP: begin
                     result_in = '{point_x: '0, point_y: '0, curve_length: '0,
                                   bad_step: 1'b1};
                     state_in  = ST_DONE;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_SQUARE_T: begin
            uu_in    = 17'((m_a + RND_HALF) >> T_FRAC);
            tt_in    = 17'((m_b + RND_HALF) >> T_FRAC);
            state_in = ST_WEIGHT;
         end
         ST_WEIGHT: begin
            if (cubic_ff) begin
               w_in[0] = 19'((34'(uu_ff) * 34'(u) + RND_HALF) >> T_FRAC);
               w_in[1] = 19'(r_b) * 19'd3;
               w_in[2] = 19'(r_c) * 19'd3;
               w_in[3] = 19'((34'(tt_ff) * 34'(t_ff) + RND_HALF) >> T_FRAC);
            end else begin
               w_in[0] = 19'(uu_ff);
               w_in[1] = 19'(tt_ff);
               w_in[2] = '0;
               w_in[3] = '0;
            end
            state_in = ST_PRODUCT;
         end
         ST_PRODUCT: begin
            state_in = ST_SUM;
         end
         ST_SUM: begin
            for (int k = 0; k < 2; k++) begin
               pt_in[k] = sat16(rounded[k]);
            end
            if (!len_mode_ff) begin
               result_in = '{point_x: pt_in[0], point_y: pt_in[1], curve_length: '0,
                             bad_step: 1'b0};
               state_in  = ST_DONE;
            end else if (first_ff) begin
               prev_in  = pt_in;
               first_in = 1'b0;
               t_in     = t_next;
               state_in = ST_SQUARE_T;
            end else begin
               state_in = ST_DELTA;
            end
         end
         ST_DELTA: begin
            for (int k = 0; k < 2; k++) begin
               sq_in[k] = dsq[k][32:0];
            end
            prev_in  = pt_ff;
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            rem_in   = 34'(sq_ff[0]) + 34'(sq_ff[1]);
            root_in  = '0;
            bit_in   = ROOT_START;
            cnt_in   = '0;
            state_in = ST_ROOT;
         end
         ST_ROOT: begin
            if (35'(rem_ff) >= trial) begin
               rem_in  = rem_ff - trial[33:0];
               root_in = (root_ff >> 1) + bit_ff;
            end else begin
               root_in = root_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == ROOT_LAST) begin
               state_in = ST_ACCUM;
            end
         end
         ST_ACCUM: begin
            acc_in = acc_sum[LEN_W] ? LEN_MAX : acc_sum[LEN_W-1:0];
            if (t_ff == T_ONE) begin
               result_in = '{point_x: '0, point_y: '0, curve_length: acc_in,
                             bad_step: 1'b0};
               state_in  = ST_DONE;
            end else begin
               t_in     = t_next;
               state_in = ST_SQUARE_T;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in       = result_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      len_mode_ff <= len_mode_in;
      cubic_ff    <= cubic_in;
      first_ff    <= first_in;
      step_ff     <= step_in;
      t_ff        <= t_in;
      uu_ff       <= uu_in;
      tt_ff       <= tt_in;
      w_ff        <= w_in;
      prod_ff     <= prod_in;
      pt_ff       <= pt_in;
      prev_ff     <= prev_in;
      sq_ff       <= sq_in;
      rem_ff      <= rem_in;
      root_ff     <= root_in;
      bit_ff      <= bit_in;
      cnt_ff      <= cnt_in;
      acc_ff      <= acc_in;
      result_ff   <= result_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_data  = rsp_ff;
   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== sv/bezier_curve_evaluator_unit.sv =====
// ----------------------------------------------------------------------------
// bezier_curve_evaluator_unit
// quadratic or cubic bezier point evaluation and cubic arc length estimate
// ----------------------------------------------------------------------------
// A point request runs through four arithmetic stages (t squares, basis
// weights, coordinate products, sum with rounding and saturation) after it
// leaves the job queue. A length request evaluates the point at t = 0 and
// then, for each of the ceil(1 / step) chords (one chord when the step is
// above one), one point, the chord deltas, a 17-step bit-serial square root
// and an accumulate step. One item is worked on at a time; a two-entry queue
// takes further requests meanwhile and an output register holds the result.
`timescale 1ns / 1ps

module bezier_curve_evaluator_unit (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  bce_pkg::req_type             req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output bce_pkg::rsp_type             rsp_data,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [bce_pkg::ADDR_W-1:0]   paddr,
   input  logic [31:0]                  pwdata,
   output logic [31:0]                  prdata,
   output logic                         pready
);
   import bce_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   logic [2:0] reg_index;
   logic       wr_en;
   logic       q_push, q_full, q_pop, q_not_empty;
   job_type    push_job, head_job;

   always_comb begin
      reg_index = paddr[4:2];
      wr_en     = psel && penable && pwrite;
      cfg_in    = cfg_ff;
      prdata    = '0;
      pready    = 1'b1;
      case (reg_index)
         REG_START:  prdata = cfg_ff.start_point;
         REG_END:    prdata = cfg_ff.end_point;
         REG_CTRL1:  prdata = cfg_ff.control_one;
         REG_CTRL2:  prdata = cfg_ff.control_two;
         REG_DEGREE: prdata = {31'b0, cfg_ff.degree_mode};
         default:    prdata = '0;
      endcase
      if (wr_en) begin
         case (reg_index)
            REG_START:  cfg_in.start_point = pwdata;
            REG_END:    cfg_in.end_point   = pwdata;
            REG_CTRL1:  cfg_in.control_one = pwdata;
            REG_CTRL2:  cfg_in.control_two = pwdata;
            REG_DEGREE: cfg_in.degree_mode = pwdata[0];
            default:    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{start_point: '0, end_point: '0, control_one: '0,
                     control_two: '0, degree_mode: 1'b1};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   bce_front u_front (
      .req_data  (req_data),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_job     (push_job)
   );

   bce_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_job  (push_job),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .head_job  (head_job)
   );

   bce_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_valid   (q_not_empty),
      .q_job     (head_job),
      .q_pop     (q_pop),
      .rsp_data  (rsp_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready)
   );

endmodule

// ===== sv/bce_checker.sv =====
// ----------------------------------------------------------------------------
// bce_checker
// result port checks, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "bezier_curve_evaluator_unit_defines.svh"

module bce_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input bce_pkg::rsp_type rsp_data
);

   `BCE_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "result dropped while stalled")
   `BCE_ASSERT_NEXT(a_rsp_stable, rsp_valid && !rsp_ready, $stable(rsp_data), "result changed while stalled")
   `BCE_ASSERT_NOW(a_bad_clean, rsp_valid && rsp_data.bad_step, rsp_data.curve_length == 0 && rsp_data.point_x == 0 && rsp_data.point_y == 0, "bad step result not zero")
   `BCE_ASSERT_NOW(a_len_no_point, rsp_valid && rsp_data.curve_length != 0, rsp_data.point_x == 0 && rsp_data.point_y == 0, "length result carries a point")

endmodule

bind bezier_curve_evaluator_unit bce_checker u_bce_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// self-checking bench for bezier_curve_evaluator_unit: requests are replayed
// through a local point and arc length predictor under several register
// settings, and every response transfer is compared with the oldest prediction
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
   import bce_pkg::*;

   localparam int IDLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 60;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [ADDR_W-1:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   bezier_curve_evaluator_unit dut (.*);

   always #5 clock = ~clock;

   req_type pending_reqs[$];
   rsp_type expected_rsps[$];
   cfg_type curve_cfg;
   int errors = 0;
   int n_point = 0, n_length = 0, n_bad = 0, n_cfg = 0, n_rsp = 0;
   bit send_hold = 1'b0;

   function automatic longint rnd16(longint v);
      return (v + (64'sd1 <<< (T_FRAC - 1))) >>> T_FRAC;
   endfunction

   function automatic longint sat16(longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   function automatic longint coord(logic [31:0] r, bit hi);
      logic signed [15:0] c;
      c = hi ? r[31:16] : r[15:0];
      return longint'(c);
   endfunction

   function automatic void curve_point(input bit cubic, input longint t,
                                       output longint px, output longint py);
      longint u, uu, tt, p1, p2, c1, c2, r, w0, w1, w2, w3;
      u = (64'sd1 <<< T_FRAC) - t;
      uu = rnd16(u * u);
      tt = rnd16(t * t);
      for (int k = 0; k < 2; k++) begin
         p1 = coord(curve_cfg.start_point, k == 0);
         p2 = coord(curve_cfg.end_point, k == 0);
         c1 = coord(curve_cfg.control_one, k == 0);
         c2 = coord(curve_cfg.control_two, k == 0);
         if (cubic) begin
            w0 = rnd16(uu * u);
            w1 = 3 * rnd16(uu * t);
            w2 = 3 * rnd16(tt * u);
            w3 = rnd16(tt * t);
            r = rnd16(w0 * p1 + w1 * c1 + w2 * c2 + w3 * p2);
         end else begin
            r = c1 + rnd16(uu * (p1 - c1) + tt * (p2 - c1));
         end
         r = sat16(r);
         if (k == 0) px = r; else py = r;
      end
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v -= res + b;
            res = (res >> 1) + b;
         end else begin
            res >>= 1;
         end
         b >>= 2;
      end
      return res;
   endfunction

   function automatic rsp_type predict_rsp(req_type rq);
      rsp_type e;
      longint x, y, ax, ay, bx, by, dx, dy, tn, tc, n, pv, one;
      longint unsigned len;
      e = '0;
      one = longint'(T_ONE);
      pv = longint'(rq.param_value);
      if (rq.opcode == OP_EVAL) begin
         curve_point(curve_cfg.degree_mode, (pv > one) ? one : pv, x, y);
         e.point_x = x[15:0];
         e.point_y = y[15:0];
      end else if (pv == 0) begin
         e.bad_step = 1'b1;
      end else begin
         n = one / pv;
         len = 0;
         tc = 0;
         curve_point(1'b1, 0, ax, ay);
         for (longint i = 0; i <= n && tc < one; i++) begin
            tn = pv * (i + 1);
            if (tn > one) tn = one;
            curve_point(1'b1, tn, bx, by);
            dx = bx - ax;
            dy = by - ay;
            len += int_sqrt(longint'(dx * dx + dy * dy));
            ax = bx;
            ay = by;
            tc = tn;
         end
         if (len > longint'(LEN_MAX)) len = LEN_MAX;
         e.curve_length = len[LEN_W-1:0];
      end
      return e;
   endfunction

   // sender: bursts of random length separated by random gaps
   always @(posedge clock) begin : sender
      int burst_left, gap_left;
      if (reset) begin
         req_valid <= 1'b0;
         burst_left = 8;
         gap_left = 0;
      end else begin
         if (req_valid && req_ready) begin
            expected_rsps.push_back(predict_rsp(req_data));
            if (req_data.opcode == OP_EVAL) n_point++;
            else if (req_data.param_value == 0) n_bad++;
            else n_length++;
         end
         if (!req_valid || req_ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_reqs.size() > 0 && !send_hold) begin
               req_data <= pending_reqs.pop_front();
               req_valid <= 1'b1;
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 30);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver: own stall pattern plus one long hold-off
   always @(posedge clock) begin : receiver
      int mode_left, mode, hold_left;
      bit hold_done;
      rsp_type e;
      if (reset) begin
         rsp_ready <= 1'b0;
         mode_left = 0;
         mode = 0;
         hold_left = 0;
         hold_done = 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            n_rsp++;
            if (expected_rsps.size() == 0) begin
               $display("%0t: unexpected response %p", $time, rsp_data);
               errors++;
            end else begin
               e = expected_rsps.pop_front();
               if (rsp_data.point_x !== e.point_x) begin
                  $display("%0t: point_x exp %0d act %0d", $time, e.point_x, rsp_data.point_x);
                  errors++;
               end
               if (rsp_data.point_y !== e.point_y) begin
                  $display("%0t: point_y exp %0d act %0d", $time, e.point_y, rsp_data.point_y);
                  errors++;
               end
               if (rsp_data.curve_length !== e.curve_length) begin
                  $display("%0t: curve_length exp %0d act %0d", $time,
                           e.curve_length, rsp_data.curve_length);
                  errors++;
               end
               if (rsp_data.bad_step !== e.bad_step) begin
                  $display("%0t: bad_step exp %0b act %0b", $time, e.bad_step,
                           rsp_data.bad_step);
                  errors++;
               end
            end
            if (n_rsp == 120 && !hold_done) begin
               hold_left = 500;
               hold_done = 1'b1;
            end
         end
         if (mode_left <= 0) begin
            mode = $urandom_range(0, 2);
            mode_left = $urandom_range(20, 200);
         end
         mode_left--;
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (mode == 0) begin
            rsp_ready <= 1'b1;
         end else if (mode == 1) begin
            rsp_ready <= ($urandom_range(0, 3) != 0);
         end else begin
            rsp_ready <= ($urandom_range(0, 3) == 0);
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin : watchdog
      int idle;
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || psel) begin
         idle = 0;
      end else begin
         idle++;
         if (idle >= IDLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
         end
      end
   end

   task automatic csr_write(logic [2:0] idx, logic [31:0] val);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= ADDR_W'(idx) << 2;
      pwdata <= val;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (idx)
         REG_START:  curve_cfg.start_point = val;
         REG_END:    curve_cfg.end_point = val;
         REG_CTRL1:  curve_cfg.control_one = val;
         REG_CTRL2:  curve_cfg.control_two = val;
         REG_DEGREE: curve_cfg.degree_mode = val[0];
         default: ;
      endcase
      n_cfg++;
   endtask

   task automatic set_curve(logic [31:0] p1, logic [31:0] p2, logic [31:0] c1,
                            logic [31:0] c2, logic deg);
      csr_write(REG_START, p1);
      csr_write(REG_END, p2);
      csr_write(REG_CTRL1, c1);
      csr_write(REG_CTRL2, c2);
      csr_write(REG_DEGREE, {31'd0, deg});
   endtask

   task automatic wait_drained();
      do @(posedge clock);
      while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic req_type make_req(logic op, logic [T_W-1:0] pv);
      req_type r;
      r.opcode = op;
      r.param_value = pv;
      return r;
   endfunction

   function automatic req_type random_req();
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 75) return make_req(OP_EVAL, T_W'($urandom_range(0, 131071)));
      if (sel < 78) return make_req(OP_LENGTH, '0);
      if (sel < 80) return make_req(OP_LENGTH, T_W'($urandom_range(512, 2047)));
      return make_req(OP_LENGTH, T_W'($urandom_range(2048, 131071)));
   endfunction

   initial begin
      logic [T_W-1:0] dir_t [8];
      logic [T_W-1:0] dir_s [8];
      dir_t = '{17'h0, 17'h1, 17'h8000, 17'hFFFF, 17'h10000,
                17'h10001, 17'h1FFFF, 17'h5555};
      dir_s = '{17'h0, 17'h10000, 17'h10001, 17'h1FFFF, 17'h8000,
                17'h5555, 17'h100, 17'h1};
      curve_cfg = '{default: '0, degree_mode: 1'b1};
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // reset values, then a plain curve with directed items
      foreach (dir_t[i]) pending_reqs.push_back(make_req(OP_EVAL, dir_t[i]));
      pending_reqs.push_back(make_req(OP_LENGTH, 17'h8000));
      wait_drained();
      for (int ph = 0; ph < 8; ph++) begin
         case (ph)
            0: set_curve(32'hF000_F000, 32'h1000_0C00, 32'hF800_2000, 32'h0800_E000, 1'b1);
            1: set_curve(32'h7FFF_7FFF, 32'h8000_8000, 32'h7FFF_8000, 32'h8000_7FFF, 1'b0);
            2: set_curve(32'h7FFF_7FFF, 32'h8000_8000, 32'h7FFF_8000, 32'h8000_7FFF, 1'b1);
            3: set_curve(32'h8000_7FFF, 32'h7FFF_8000, 32'h8000_8000, 32'h7FFF_7FFF, 1'b0);
            default: set_curve($urandom, $urandom, $urandom, $urandom, $urandom_range(0, 1));
         endcase
         if (ph < 2) begin
            foreach (dir_t[i]) pending_reqs.push_back(make_req(OP_EVAL, dir_t[i]));
            foreach (dir_s[i])
               if (dir_s[i] != 17'h1 || ph == 0)
                  if (dir_s[i] != 17'h1) pending_reqs.push_back(make_req(OP_LENGTH, dir_s[i]));
         end
         for (int i = 0; i < 180; i++) pending_reqs.push_back(random_req());
         if (ph == 4) begin
            // sender waits for every outstanding response mid-phase
            do @(posedge clock);
            while (pending_reqs.size() > 90);
            send_hold = 1'b1;
            do @(posedge clock);
            while (req_valid || expected_rsps.size() != 0);
            send_hold = 1'b0;
         end
         wait_drained();
      end

      $display("covered %0d point and %0d length requests, %0d zero steps, %0d register writes",
               n_point, n_length, n_bad, n_cfg);
      if (errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+sv
sv/bce_pkg.sv
sv/bce_front.sv
sv/bce_queue.sv
sv/bce_engine.sv
sv/bezier_curve_evaluator_unit.sv
sv/bce_checker.sv
sim/tb.sv
